### hdl/pso_pkg.sv
// Shared constants, types and helpers of the pairwise surface obstacle scan.
package pso_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int OUT_IDX_W  = 4;

  localparam int COORD_W    = 12;
  localparam int DROP_W     = 12;
  localparam int NEAR_W     = 12;
  localparam int SLOPE_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int DIFF_W = COORD_W + 1;        // difference of two coordinates
  localparam int SQ_W   = 2 * COORD_W;        // square of a difference
  localparam int DIST_W = SQ_W + 1;           // dx^2 + dz^2
  localparam int LIM_W  = 2 * NEAR_W;         // near_limit^2
  localparam int DY10_W = SQ_W + 4;           // 10 * dy^2
  localparam int SP1_W  = SLOPE_W + 1;        // slope_limit + 1
  localparam int PROD_W = DIST_W + SP1_W;     // (slope_limit + 1) * dist

  localparam logic [DROP_W-1:0]  DROP_RESET  = DROP_W'(50);
  localparam logic [NEAR_W-1:0]  NEAR_RESET  = NEAR_W'(50);
  localparam logic [SLOPE_W-1:0] SLOPE_RESET = SLOPE_W'(10);
  localparam logic [LIM_W-1:0]   LIM_RESET   = LIM_W'(50 * 50);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DROP_LIMIT  = 2'd0,
    REG_NEAR_LIMIT  = 2'd1,
    REG_SLOPE_LIMIT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OUTC_NONE     = 2'd0,
    OUTC_OBSTACLE = 2'd1,
    OUTC_STOP     = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [DROP_W-1:0] drop;
    logic [LIM_W-1:0]  lim;
    logic [SP1_W-1:0]  slope_p1;
  } cfg_t;

  typedef struct packed {
    logic                      v;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [IDX_W-1:0]          slot;
    logic                      clr;
    logic [IDX_W-1:0]          last_idx;
  } token_t;

  typedef struct packed {
    logic             v;
    logic [IDX_W-1:0] earlier;
    logic [IDX_W-1:0] newer;
    outcome_e         outcome;
    logic             last;
  } result_t;

  function automatic logic [IDX_W-1:0] highest_set(input logic [MAX_POINTS-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage

### hdl/pso_point_if.sv
// Input channel carrying one surface point per word.
interface pso_point_if;
  logic                               valid;
  logic                               ready;
  logic signed [pso_pkg::COORD_W-1:0] point_x;
  logic signed [pso_pkg::COORD_W-1:0] point_y;
  logic signed [pso_pkg::COORD_W-1:0] point_z;
  logic                               end_of_set;

  modport source (output valid, point_x, point_y, point_z, end_of_set, input ready);
  modport sink   (input valid, point_x, point_y, point_z, end_of_set, output ready);
endinterface

### hdl/pso_result_if.sv
// Output channel carrying one pair test result per word.
interface pso_result_if;
  logic                           valid;
  logic                           ready;
  logic [pso_pkg::OUT_IDX_W-1:0]  earlier_index;
  logic [pso_pkg::OUT_IDX_W-1:0]  newer_index;
  logic [1:0]                     outcome;
  logic                           last_of_run;

  modport source (output valid, earlier_index, newer_index, outcome, last_of_run,
                  input ready);
  modport sink   (input valid, earlier_index, newer_index, outcome, last_of_run,
                  output ready);
endinterface

### hdl/pso_cell.sv
// One store cell: holds a point, tests the passing new point against it, forwards it.
module pso_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             clear_i,
  input  logic [pso_pkg::IDX_W-1:0] idx_i,
  input  pso_pkg::cfg_t    cfg_i,
  input  pso_pkg::token_t  tok_i,
  output pso_pkg::token_t  tok_o,
  output pso_pkg::result_t res_o,
  output logic             active_o,
  output logic             busy_o,
  output logic             clr_o
);
  import pso_pkg::*;

  logic signed [COORD_W-1:0] px_q, py_q, pz_q;
  logic                      active_q, active_d;
  logic                      tok_v_q, tok_v_d;
  token_t                    tok_q;

  logic                      s1_v_q, s1_v_d;
  logic [DIST_W-1:0]         s1_dist_q;
  logic [SQ_W-1:0]           s1_dysq_q;
  logic                      s1_stop_q;
  logic                      s1_dynz_q;
  logic [IDX_W-1:0]          s1_slot_q;
  logic                      s1_last_q;

  logic                      is_slot;
  logic signed [DIFF_W-1:0]  dx, dy, dz;
  logic signed [2*DIFF_W-1:0] dx_full, dy_full, dz_full;
  logic [DIST_W-1:0]         dist_d;
  logic signed [DIFF_W:0]    dz_plus;
  logic                      stop_d;

  logic [DY10_W-1:0]         dy10;
  logic [PROD_W-1:0]         prod;
  logic                      near_ok, steep;
  outcome_e                  outcome;

  assign is_slot = tok_i.v && (tok_i.slot == idx_i);

  // First stage: differences, squares and the drop test against the stored point
  assign dx = DIFF_W'(tok_i.x) - DIFF_W'(px_q);
  assign dy = DIFF_W'(tok_i.y) - DIFF_W'(py_q);
  assign dz = DIFF_W'(tok_i.z) - DIFF_W'(pz_q);
  assign dx_full = dx * dx;
  assign dy_full = dy * dy;
  assign dz_full = dz * dz;
  assign dist_d  = DIST_W'(dx_full[SQ_W-1:0]) + DIST_W'(dz_full[SQ_W-1:0]);
  assign dz_plus = (DIFF_W+1)'(dz) + $signed({2'b00, cfg_i.drop});
  assign stop_d  = dz_plus[DIFF_W];

  // Second stage: floor(10*dy^2/dist) > s  holds exactly when  10*dy^2 >= (s+1)*dist
  assign dy10    = DY10_W'({s1_dysq_q, 3'b000}) + DY10_W'({s1_dysq_q, 1'b0});
  assign prod    = PROD_W'(s1_dist_q) * PROD_W'(cfg_i.slope_p1);
  assign near_ok = s1_dist_q < DIST_W'(cfg_i.lim);
  assign steep   = PROD_W'(dy10) >= prod;

  always_comb begin
    if (s1_stop_q) begin
      outcome = OUTC_STOP;
    end else if (s1_dist_q == '0) begin
      outcome = s1_dynz_q ? OUTC_OBSTACLE : OUTC_NONE;
    end else if (near_ok && steep) begin
      outcome = OUTC_OBSTACLE;
    end else begin
      outcome = OUTC_NONE;
    end
  end

  always_comb begin
    active_d = active_q;
    if (s1_v_q && s1_stop_q) active_d = 1'b0;
    if (is_slot) active_d = !tok_i.clr;
    if (clear_i) active_d = 1'b0;
  end

  // Pass the word on only while it has not reached its own slot
  assign tok_v_d = tok_i.v && !is_slot;
  assign s1_v_d  = tok_i.v && active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      tok_v_q  <= 1'b0;
      s1_v_q   <= 1'b0;
    end else if (adv_i) begin
      active_q <= active_d;
      tok_v_q  <= tok_v_d;
      s1_v_q   <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_i;
      if (is_slot) begin
        px_q <= tok_i.x;
        py_q <= tok_i.y;
        pz_q <= tok_i.z;
      end
      if (s1_v_d) begin
        s1_dist_q <= dist_d;
        s1_dysq_q <= dy_full[SQ_W-1:0];
        s1_stop_q <= stop_d;
        s1_dynz_q <= (dy != '0);
        s1_slot_q <= tok_i.slot;
        s1_last_q <= (tok_i.last_idx == idx_i);
      end
    end
  end

  always_comb begin
    tok_o   = tok_q;
    tok_o.v = tok_v_q;
  end

  always_comb begin
    res_o = '0;
    if (s1_v_q) begin
      res_o.v       = 1'b1;
      res_o.earlier = idx_i;
      res_o.newer   = s1_slot_q;
      res_o.outcome = outcome;
      res_o.last    = s1_last_q;
    end
  end

  assign active_o = active_q;
  assign busy_o   = tok_v_q | s1_v_q;
  assign clr_o    = adv_i && is_slot && tok_i.clr;

endmodule

### hdl/pairwise_surface_obstacle_scan_unit.sv
// Pairwise surface obstacle scan: a chain of store cells that the new point walks along.
// Path: an accepted point is registered in the launch stage, passes one cell register per slot up to
// the first active earlier point, and its first result is registered there and then in the output register.
// Throughput: a point stored in slot s walks the cell chain up to that slot; one result per cycle leaves the
// chain while the output is not stalled, and the next point is taken once the chain is empty.
// Reset: all marks and counts cleared, limits at 50, 50 and 10; stored points unset.
module pairwise_surface_obstacle_scan_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  pso_point_if.sink                          point_i,
  pso_result_if.source                       result_o,
  input  logic                               cfg_we_i,
  input  logic [pso_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pso_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import pso_pkg::*;

  logic [DROP_W-1:0]  drop_q;
  logic [NEAR_W-1:0]  near_q;
  logic [SLOPE_W-1:0] slope_q;
  logic [LIM_W-1:0]   lim_q;
  cfg_t               cfg;

  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic               launch_v_q;
  token_t             launch_q;

  token_t             tok_c [MAX_POINTS+1];
  result_t            res_c [MAX_POINTS];
  logic [MAX_POINTS-1:0] active_vec, busy_vec, clr_vec, res_v_vec;
  result_t            res_any;
  logic               clear_all;

  logic               adv, accept, set_end;
  logic               out_v_q;
  result_t            out_q;

  assign cfg.drop     = drop_q;
  assign cfg.lim      = lim_q;
  assign cfg.slope_p1 = SP1_W'(slope_q) + SP1_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q  <= DROP_RESET;
      near_q  <= NEAR_RESET;
      slope_q <= SLOPE_RESET;
      lim_q   <= LIM_RESET;
    end else begin
      lim_q <= near_q * near_q;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DROP_LIMIT:  drop_q  <= cfg_data_i[DROP_W-1:0];
          REG_NEAR_LIMIT:  near_q  <= cfg_data_i[NEAR_W-1:0];
          REG_SLOPE_LIMIT: slope_q <= cfg_data_i[SLOPE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // The chain steps only when the output register can take a word
  assign adv    = !out_v_q || result_o.ready;
  assign point_i.ready = !launch_v_q && (busy_vec == '0);
  assign accept = point_i.valid && point_i.ready;
  assign set_end = point_i.end_of_set || (cnt_q == IDX_W'(MAX_POINTS - 1));
  assign cnt_d  = set_end ? '0 : cnt_q + IDX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      launch_v_q <= 1'b0;
    end else if (accept) begin
      cnt_q      <= cnt_d;
      launch_v_q <= 1'b1;
    end else if (adv) begin
      launch_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      launch_q.v        <= 1'b1;
      launch_q.x        <= point_i.point_x;
      launch_q.y        <= point_i.point_y;
      launch_q.z        <= point_i.point_z;
      launch_q.slot     <= cnt_q;
      launch_q.clr      <= set_end;
      launch_q.last_idx <= highest_set(active_vec);
    end
  end

  always_comb begin
    tok_c[0]   = launch_q;
    tok_c[0].v = launch_v_q;
  end

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    pso_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .clear_i  (clear_all),
      .idx_i    (IDX_W'(k)),
      .cfg_i    (cfg),
      .tok_i    (tok_c[k]),
      .tok_o    (tok_c[k+1]),
      .res_o    (res_c[k]),
      .active_o (active_vec[k]),
      .busy_o   (busy_vec[k]),
      .clr_o    (clr_vec[k])
    );
    assign res_v_vec[k] = res_c[k].v;
  end

  assign clear_all = |clr_vec;

  // At most one cell finishes a test per step; idle cells drive zero
  always_comb begin
    res_any = '0;
    for (int k = 0; k < MAX_POINTS; k++) begin
      res_any = result_t'(res_any | res_c[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= res_any.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_any.v) out_q <= res_any;
  end

  assign result_o.valid         = out_v_q;
  assign result_o.earlier_index = OUT_IDX_W'(out_q.earlier);
  assign result_o.newer_index   = OUT_IDX_W'(out_q.newer);
  assign result_o.outcome       = out_q.outcome;
  assign result_o.last_of_run   = out_q.last;

  a_one_test_per_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(res_v_vec))
    else $error("more than one cell finished a test in the same step");

  a_clear_after_count_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_all |-> (cnt_q == '0))
    else $error("set cleared while the point count is not back at zero");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res_any.v && res_any.last) |=> (res_v_vec == '0))
    else $error("a test finished after the last word of the run");

endmodule
